/* sv/uete_pkg.sv */
`default_nettype none
package uete_pkg;
	localparam int NUM_ENDPOINTS_DEF = 8;
	localparam int MAX_PACKET_LIMIT_DEF = 1024;
	localparam int EP0_PACKET_LIMIT_DEF = 64;

	localparam logic [3:0] ACT_OPEN = 4'd0;
	localparam logic [3:0] ACT_CLOSE = 4'd1;
	localparam logic [3:0] ACT_STALL = 4'd2;
	localparam logic [3:0] ACT_UNSTALL = 4'd3;
	localparam logic [3:0] ACT_QUERY = 4'd4;
	localparam logic [3:0] ACT_START = 4'd5;
	localparam logic [3:0] ACT_SETADDR = 4'd6;
	localparam logic [3:0] ACT_PKTDONE = 4'd7;
	localparam logic [3:0] ACT_BUSRST = 4'd8;

	localparam logic [1:0] HS_ACK = 2'd0;
	localparam logic [1:0] HS_NAK = 2'd1;
	localparam logic [1:0] HS_STALL = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BADARG = 2'd1;
	localparam logic [1:0] ST_DISABLED = 2'd2;
	localparam logic [1:0] ST_MISALIGN = 2'd3;

	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_SETUP = 3'd1;
	localparam logic [2:0] EV_OUT = 3'd2;
	localparam logic [2:0] EV_IN = 3'd3;
	localparam logic [2:0] EV_RESET = 3'd4;

	localparam logic [23:0] MASK24 = 24'hFFFFFF;
	localparam logic [31:0] ALIGN_MASK = 32'h03;
	localparam logic [23:0] SETUP_BYTES = 24'd8;

	typedef struct packed {
		logic [3:0]  action;
		logic [3:0]  ep_index;
		logic        dir_in;
		logic [10:0] max_packet;
		logic [1:0]  ep_kind;
		logic [23:0] xfer_length;
		logic [31:0] buf_address;
		logic [10:0] rx_count;
		logic        is_setup;
		logic [6:0]  new_address;
		logic [15:0] setup_wlength;
		logic        setup_dir_in;
		logic        ep_ok;
		logic        bad;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  event_res;
		logic [23:0] event_length;
		logic [10:0] arm_length;
		logic [31:0] arm_address;
		logic [1:0]  handshake;
		logic        data_toggle;
		logic [6:0]  device_address;
		logic        stalled;
	} result_t;

	function automatic logic [23:0] add24(input logic [23:0] a, input logic [23:0] b);
		logic [24:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[24] ? MASK24 : s[23:0];
	endfunction

	function automatic logic [23:0] sub24(input logic [23:0] a, input logic [23:0] b);
		return (a > b) ? a - b : 24'd0;
	endfunction
endpackage
`default_nettype wire

/* sv/uete_front.sv */
`default_nettype none
module uete_front import uete_pkg::*; #(
	parameter int NUM_ENDPOINTS = NUM_ENDPOINTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  action,
	input  wire logic [3:0]  ep_index,
	input  wire logic        dir_in,
	input  wire logic [10:0] max_packet,
	input  wire logic [1:0]  ep_kind,
	input  wire logic [23:0] xfer_length,
	input  wire logic [31:0] buf_address,
	input  wire logic [10:0] rx_count,
	input  wire logic        is_setup,
	input  wire logic [6:0]  new_address,
	input  wire logic [15:0] setup_wlength,
	input  wire logic        setup_dir_in,
	output logic             q_valid,
	input  wire logic        q_pop,
	output item_t            q_item
);
	// two-entry queue to the back end
	item_t  mem_q [2];
	logic   wp_q, rp_q;
	logic [1:0] cnt_q;
	item_t  it;
	logic   push;

	always_comb begin
		it.action = action;
		it.ep_index = ep_index;
		it.dir_in = dir_in;
		it.max_packet = max_packet;
		it.ep_kind = ep_kind;
		it.xfer_length = xfer_length;
		it.buf_address = buf_address;
		it.rx_count = rx_count;
		it.is_setup = is_setup;
		it.new_address = new_address;
		it.setup_wlength = setup_wlength;
		it.setup_dir_in = setup_dir_in;
		it.ep_ok = {1'b0, ep_index} < 5'(NUM_ENDPOINTS);
		it.bad = (action > ACT_BUSRST) ||
			(!it.ep_ok && action != ACT_SETADDR && action != ACT_BUSRST);
	end

	assign in_ready = cnt_q != 2'd2;
	assign push = in_valid && in_ready;
	assign q_valid = cnt_q != 2'd0;
	assign q_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= it;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	a_nopop_empty: assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue overflow");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !q_pop) |=> cnt_q == 2'd2)
		else $error("queue lost an entry");
endmodule
`default_nettype wire

/* sv/uete_back.sv */
`default_nettype none
module uete_back import uete_pkg::*; #(
	parameter int MAX_PACKET_LIMIT = MAX_PACKET_LIMIT_DEF,
	parameter int EP0_PACKET_LIMIT = EP0_PACKET_LIMIT_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	output logic      q_pop,
	input  item_t     q_item,
	output logic      out_valid,
	input  wire logic out_ready,
	output result_t   res
);
	// table entry index {dir, ep}
	logic [10:0] mp_q   [32];
	logic [1:0]  ty_q   [32];
	logic        en_q   [32];
	logic        stl_q  [32];
	logic [1:0]  hs_q   [32];
	logic [31:0] bp_q   [32];
	logic [23:0] left_q [32];
	logic [23:0] done_q [32];
	logic        rxt_q, txt_q;
	logic [6:0]  pend_q, appl_q;
	logic [15:0] slen_q;
	logic        sin_q;

	// stage 1: latch item and read addressed entry (a setup also sets EP0 IN to NAK)
	item_t       it_s1;
	logic        v_s1;
	logic        busy_q;
	result_t     res_q;
	logic        ov_q;

	logic [4:0]  ix;
	logic [10:0] mp;
	logic [31:0] bp;
	logic [23:0] lf, dn;
	logic        en;
	logic [1:0]  hs;

	assign ix = {it_s1.dir_in, it_s1.ep_index};
	assign mp = mp_q[ix];
	assign bp = bp_q[ix];
	assign lf = left_q[ix];
	assign dn = done_q[ix];
	assign en = en_q[ix];
	assign hs = hs_q[ix];

	assign q_pop = q_valid && !busy_q && !v_s1;
	assign out_valid = ov_q;
	assign res = res_q;

	// next-state computation for one item
	logic        w_ent, clr;
	logic [10:0] n_mp;
	logic [1:0]  n_ty, n_hs;
	logic        n_en, n_stl;
	logic [31:0] n_bp;
	logic [23:0] n_lf, n_dn;
	logic        w_hs_in0, w_hs_out0;
	logic        n_rxt, n_txt;
	logic [6:0]  n_pend, n_appl;
	logic [15:0] n_slen;
	logic        n_sin;
	result_t     r;
	logic        ftog;
	logic [23:0] mp24, lm, rc24;
	logic        ep0;
	logic [10:0] lim;

	always_comb begin
		w_ent = 1'b0; clr = 1'b0; w_hs_in0 = 1'b0; w_hs_out0 = 1'b0; ftog = 1'b0;
		n_mp = mp; n_ty = ty_q[ix]; n_en = en; n_stl = stl_q[ix]; n_hs = hs;
		n_bp = bp; n_lf = lf; n_dn = dn;
		n_rxt = rxt_q; n_txt = txt_q; n_pend = pend_q; n_appl = appl_q;
		n_slen = slen_q; n_sin = sin_q;
		r = '0;
		ep0 = it_s1.ep_index == 4'd0;
		mp24 = {13'd0, mp};
		rc24 = {13'd0, it_s1.rx_count};
		lm = '0;
		lim = ep0 ? 11'(EP0_PACKET_LIMIT) : 11'(MAX_PACKET_LIMIT);
		if (it_s1.bad) begin
			r.status = ST_BADARG;
		end else begin
			case (it_s1.action)
				ACT_OPEN: begin
					if (it_s1.max_packet == 11'd0 || it_s1.max_packet > lim) begin
						r.status = ST_BADARG;
					end else begin
						w_ent = 1'b1;
						n_mp = it_s1.max_packet; n_ty = it_s1.ep_kind; n_en = 1'b1;
						n_hs = (ep0 && !it_s1.dir_in) ? HS_ACK : HS_NAK;
					end
				end
				ACT_CLOSE: begin
					w_ent = 1'b1; n_hs = HS_NAK; n_en = 1'b0;
				end
				ACT_STALL: begin
					w_ent = 1'b1; n_hs = HS_STALL; n_stl = 1'b1;
				end
				ACT_UNSTALL: begin
					w_ent = 1'b1; n_stl = 1'b0;
					n_hs = (ep0 && !it_s1.dir_in) ? HS_ACK : HS_NAK;
				end
				ACT_QUERY: r.stalled = hs == HS_STALL;
				ACT_START: begin
					if (it_s1.buf_address == 32'd0 && it_s1.xfer_length != 24'd0)
						r.status = ST_BADARG;
					else if (!en)
						r.status = ST_DISABLED;
					else if (!ep0 && (it_s1.buf_address & ALIGN_MASK) != 32'd0)
						r.status = ST_MISALIGN;
					else begin
						w_ent = 1'b1;
						n_bp = it_s1.buf_address; n_lf = it_s1.xfer_length;
						n_dn = 24'd0; n_hs = HS_ACK;
						r.arm_address = it_s1.buf_address;
						if (it_s1.dir_in)
							r.arm_length = (it_s1.xfer_length < mp24) ?
								it_s1.xfer_length[10:0] : mp;
						else if (ep0 && it_s1.xfer_length == 24'd0)
							ftog = 1'b1;
					end
				end
				ACT_SETADDR: begin
					if (it_s1.new_address == 7'd0) n_appl = 7'd0;
					n_pend = it_s1.new_address;
				end
				ACT_PKTDONE: begin
					w_ent = 1'b1;
					n_hs = HS_NAK;
					if (!it_s1.dir_in) begin
						if (ep0 && it_s1.is_setup) begin
							n_slen = it_s1.setup_wlength; n_sin = it_s1.setup_dir_in;
							n_rxt = 1'b1; n_txt = 1'b1; w_hs_in0 = 1'b1;
							r.event_res = EV_SETUP; r.event_length = SETUP_BYTES;
						end else if (ep0) begin
							if (it_s1.rx_count != 11'd0) n_rxt = ~rxt_q;
							n_dn = add24(dn, rc24); n_lf = sub24(lf, rc24);
							r.event_res = EV_OUT; r.event_length = rc24;
							if (it_s1.rx_count == 11'd0) begin
								n_hs = HS_ACK; n_rxt = 1'b1; n_txt = 1'b1;
							end
						end else begin
							n_bp = bp + {21'd0, it_s1.rx_count};
							n_dn = add24(dn, rc24); n_lf = sub24(lf, rc24);
							if (it_s1.rx_count < mp || n_lf == 24'd0) begin
								r.event_res = EV_OUT; r.event_length = n_dn;
							end else begin
								r.arm_address = n_bp; n_hs = HS_ACK;
							end
						end
					end else if (ep0) begin
						if (lf >= mp24) begin
							n_lf = lf - mp24; n_dn = add24(dn, mp24); n_txt = ~txt_q;
						end else begin
							n_dn = add24(dn, lf); n_lf = 24'd0; n_txt = 1'b1;
						end
						r.event_res = EV_IN; r.event_length = n_dn;
						if (pend_q != 7'd0) begin
							n_appl = pend_q; n_pend = 7'd0;
						end
						// no data stage left: EP0 OUT goes back to ACK for status
						if (slen_q == 16'd0 || !sin_q) begin
							w_hs_out0 = 1'b1; n_txt = 1'b1;
						end
					end else if (lf > mp24) begin
						n_bp = bp + {21'd0, mp};
						lm = lf - mp24;
						n_lf = lm; n_dn = add24(dn, mp24);
						r.arm_length = (lm < mp24) ? lm[10:0] : mp;
						r.arm_address = n_bp; n_hs = HS_ACK;
					end else begin
						n_dn = add24(dn, lf); n_lf = 24'd0;
						r.event_res = EV_IN; r.event_length = n_dn;
					end
				end
				ACT_BUSRST: begin
					clr = 1'b1; r.event_res = EV_RESET;
					n_rxt = 1'b1; n_txt = 1'b1; n_pend = 7'd0; n_appl = 7'd0;
					n_slen = 16'd0; n_sin = 1'b0;
				end
				default: r.status = ST_BADARG;
			endcase
		end
		if (clr)
			r.handshake = it_s1.ep_ok ? ((ep0 && !it_s1.dir_in) ? HS_ACK : HS_NAK) : HS_NAK;
		else if (!it_s1.ep_ok)
			r.handshake = HS_NAK;
		else if (w_ent)
			r.handshake = n_hs;
		else
			r.handshake = hs;
		// setup on EP0 OUT forces EP0 IN to NAK; does not touch OUT query result
		r.data_toggle = ftog ? 1'b1 : (it_s1.dir_in ? n_txt : n_rxt);
		r.device_address = n_appl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 32; i++) begin
				mp_q[i] <= (i[3:0] == 4'd0) ? 11'd64 : 11'd0;
				ty_q[i] <= 2'd0;
				en_q[i] <= i[3:0] == 4'd0;
				stl_q[i] <= 1'b0;
				hs_q[i] <= (i == 0) ? HS_ACK : HS_NAK;
				bp_q[i] <= 32'd0;
				left_q[i] <= 24'd0;
				done_q[i] <= 24'd0;
			end
		end else if (v_s1) begin
			if (clr) begin
				for (int i = 0; i < 32; i++) begin
					mp_q[i] <= (i[3:0] == 4'd0) ? 11'd64 : 11'd0;
					ty_q[i] <= 2'd0;
					en_q[i] <= i[3:0] == 4'd0;
					stl_q[i] <= 1'b0;
					hs_q[i] <= (i == 0) ? HS_ACK : HS_NAK;
					bp_q[i] <= 32'd0;
					left_q[i] <= 24'd0;
					done_q[i] <= 24'd0;
				end
			end else begin
				if (w_ent && !it_s1.bad) begin
					mp_q[ix] <= n_mp; ty_q[ix] <= n_ty; en_q[ix] <= n_en;
					stl_q[ix] <= n_stl; hs_q[ix] <= n_hs; bp_q[ix] <= n_bp;
					left_q[ix] <= n_lf; done_q[ix] <= n_dn;
				end
				if (w_hs_in0) hs_q[16] <= HS_NAK;
				if (w_hs_out0) hs_q[0] <= HS_ACK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) it_s1 <= q_item;
		if (v_s1) res_q <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; busy_q <= 1'b0; ov_q <= 1'b0;
			rxt_q <= 1'b1; txt_q <= 1'b1; pend_q <= 7'd0; appl_q <= 7'd0;
			slen_q <= 16'd0; sin_q <= 1'b0;
		end else begin
			v_s1 <= q_pop;
			if (v_s1) begin
				ov_q <= 1'b1; busy_q <= 1'b1;
				rxt_q <= n_rxt; txt_q <= n_txt; pend_q <= n_pend; appl_q <= n_appl;
				slen_q <= n_slen; sin_q <= n_sin;
			end else if (ov_q && out_ready) begin
				ov_q <= 1'b0; busy_q <= 1'b0;
			end
		end
	end

	a_one: assert property (@(posedge clk) disable iff (!arst_n) !(v_s1 && ov_q))
		else $error("result overwrite");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !ov_q)
		else $error("pop while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_ready) |=> ov_q && $stable(res_q))
		else $error("result dropped");
endmodule
`default_nettype wire

/* sv/usb_endpoint_transfer_engine.sv */
// An accepted item passes through the queue, the stage-1 item register and
// the result register. The back end holds one item at a time until its
// result is taken (table read, then read-modify-write).
// A two-entry queue lets the input side keep accepting meanwhile.
// Reset (arst_n low): endpoint table back to power-on values, queues empty.
`default_nettype none
module usb_endpoint_transfer_engine import uete_pkg::*; #(
	parameter int NUM_ENDPOINTS = NUM_ENDPOINTS_DEF,
	parameter int MAX_PACKET_LIMIT = MAX_PACKET_LIMIT_DEF,
	parameter int EP0_PACKET_LIMIT = EP0_PACKET_LIMIT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  action,
	input  wire logic [3:0]  ep_index,
	input  wire logic        dir_in,
	input  wire logic [10:0] max_packet,
	input  wire logic [1:0]  ep_kind,
	input  wire logic [23:0] xfer_length,
	input  wire logic [31:0] buf_address,
	input  wire logic [10:0] rx_count,
	input  wire logic        is_setup,
	input  wire logic [6:0]  new_address,
	input  wire logic [15:0] setup_wlength,
	input  wire logic        setup_dir_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [2:0]       event_res,
	output logic [23:0]      event_length,
	output logic [10:0]      arm_length,
	output logic [31:0]      arm_address,
	output logic [1:0]       handshake,
	output logic             data_toggle,
	output logic [6:0]       device_address,
	output logic             stalled
);
	logic    q_valid, q_pop;
	item_t   q_item;
	result_t res;

	uete_front #(.NUM_ENDPOINTS(NUM_ENDPOINTS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .action, .ep_index, .dir_in,
		.max_packet, .ep_kind, .xfer_length, .buf_address, .rx_count, .is_setup,
		.new_address, .setup_wlength, .setup_dir_in, .q_valid, .q_pop, .q_item
	);

	uete_back #(.MAX_PACKET_LIMIT(MAX_PACKET_LIMIT), .EP0_PACKET_LIMIT(EP0_PACKET_LIMIT)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_item, .out_valid, .out_ready, .res
	);

	assign status = res.status;
	assign event_res = res.event_res;
	assign event_length = res.event_length;
	assign arm_length = res.arm_length;
	assign arm_address = res.arm_address;
	assign handshake = res.handshake;
	assign data_toggle = res.data_toggle;
	assign device_address = res.device_address;
	assign stalled = res.stalled;
endmodule
`default_nettype wire
